### hw/rtl/stepper_angle_position_controller_macros.svh
// assertion macros for the stepper angle position controller checker
// no dependencies; included by the checker file only
`ifndef STEPPER_ANGLE_POSITION_CONTROLLER_MACROS_SVH
`define STEPPER_ANGLE_POSITION_CONTROLLER_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define SAPC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define SAPC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/sapc_pkg.sv
// shared constants, codes and types of the stepper angle position controller
// no dependencies
`timescale 1ns / 1ps

package sapc_pkg;

    localparam int ANGLE_W = 32;
    localparam int SPR_W   = 16;
    localparam int PROD_W  = 48;

    // action codes
    localparam logic [2:0] ACT_TICK      = 3'd0;
    localparam logic [2:0] ACT_FORWARD   = 3'd1;
    localparam logic [2:0] ACT_REVERSE   = 3'd2;
    localparam logic [2:0] ACT_STOP      = 3'd3;
    localparam logic [2:0] ACT_ROTATE_TO = 3'd4;
    localparam logic [2:0] ACT_ROTATE_BY = 3'd5;
    localparam logic [2:0] ACT_SET_ZERO  = 3'd6;

    // run modes
    localparam logic [2:0] MODE_STOPPED = 3'd0;
    localparam logic [2:0] MODE_FORWARD = 3'd1;
    localparam logic [2:0] MODE_REVERSE = 3'd2;
    localparam logic [2:0] MODE_TARGET  = 3'd3;
    localparam logic [2:0] MODE_REACHED = 3'd4;

    // step pulse codes
    localparam logic [1:0] PULSE_NONE = 2'd0;
    localparam logic [1:0] PULSE_FWD  = 2'd1;
    localparam logic [1:0] PULSE_BWD  = 2'd2;

    localparam logic [SPR_W-1:0] SPR_RESET = 16'd200;

    // 360 deg in q8 is 92160 = 45 * 2^11
    localparam logic [SPR_W-1:0]  ROT_ODD     = 16'd45;
    localparam int                ROT_SHIFT   = 11;
    localparam logic [PROD_W-1:0] HALF_ROT_Q8 = 48'd46080;

    typedef enum logic {
        CVT_D2S = 1'b0,
        CVT_S2D = 1'b1
    } cvt_kind_t;

    typedef struct packed {
        logic               start;
        cvt_kind_t          kind;
        logic               sign;
        logic [ANGLE_W-1:0] mag;
    } cvt_req_t;

    typedef struct packed {
        logic               done;
        logic [ANGLE_W-1:0] result;
    } cvt_rsp_t;

endpackage

### hw/rtl/sapc_cmd_if.sv
// command channel: valid/ready handshake with action and angle payload
// no dependencies
`timescale 1ns / 1ps

interface sapc_cmd_if;
    logic               valid;
    logic               ready;
    logic [2:0]         action;
    logic signed [31:0] angle;

    modport source (output valid, output action, output angle, input ready);
    modport sink (input valid, input action, input angle, output ready);
endinterface

### hw/rtl/sapc_res_if.sv
// result channel: valid/ready handshake with pulse, angles and mode
// no dependencies
`timescale 1ns / 1ps

interface sapc_res_if;
    logic               valid;
    logic               ready;
    logic [1:0]         step_pulse;
    logic signed [31:0] position_degrees;
    logic signed [31:0] target_degrees;
    logic signed [31:0] reply_degrees;
    logic [2:0]         mode;

    modport source (output valid, output step_pulse, output position_degrees,
                    output target_degrees, output reply_degrees, output mode,
                    input ready);
    modport sink (input valid, input step_pulse, input position_degrees,
                  input target_degrees, input reply_degrees, input mode,
                  output ready);
endinterface

### hw/rtl/sapc_cvt.sv
// bit-serial angle/step converter: shift-add multiply then restoring divide
// depends on sapc_pkg
`timescale 1ns / 1ps

module sapc_cvt (
    input  logic                         clk,
    input  logic                         rst_n,
    input  sapc_pkg::cvt_req_t           req,
    input  logic [sapc_pkg::SPR_W-1:0]   spr,
    output sapc_pkg::cvt_rsp_t           rsp
);
    import sapc_pkg::*;

    typedef enum logic [4:0] {
        CV_IDLE = 5'b00001,
        CV_MUL  = 5'b00010,
        CV_PREP = 5'b00100,
        CV_DIV  = 5'b01000,
        CV_FIN  = 5'b10000
    } cv_state_t;

    localparam logic [5:0] MUL_LAST = 6'(SPR_W - 1);
    localparam logic [5:0] DIV_LAST = 6'(PROD_W - 1);

    cv_state_t           state_reg, state_next;
    logic [5:0]          cnt_reg, cnt_next;
    cvt_kind_t           kind_reg, kind_next;
    logic                sign_reg, sign_next;
    logic [ANGLE_W-1:0]  mcand_reg, mcand_next;
    logic [SPR_W-1:0]    mplier_reg, mplier_next;
    logic [PROD_W-1:0]   acc_reg, acc_next;
    logic [SPR_W-1:0]    rem_reg, rem_next;
    logic [PROD_W-1:0]   quo_reg, quo_next;
    logic [SPR_W-1:0]    dvsr_reg, dvsr_next;

    logic [SPR_W:0]      rem_ext;
    logic [SPR_W:0]      rem_diff;
    logic                rem_fits;
    logic [PROD_W:0]     round_sum;
    logic [ANGLE_W-1:0]  q_low;
    logic                q_big;
    logic [ANGLE_W-1:0]  result;

    always_comb
    begin
        rem_ext   = {rem_reg, quo_reg[PROD_W-1]};
        rem_diff  = rem_ext - {1'b0, dvsr_reg};
        rem_fits  = (rem_ext >= {1'b0, dvsr_reg});
        round_sum = {1'b0, acc_reg} + {1'b0, HALF_ROT_Q8};

        state_next  = state_reg;
        cnt_next    = cnt_reg;
        kind_next   = kind_reg;
        sign_next   = sign_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        acc_next    = acc_reg;
        rem_next    = rem_reg;
        quo_next    = quo_reg;
        dvsr_next   = dvsr_reg;

        case (state_reg)
            CV_IDLE:
            begin
                if (req.start)
                begin
                    kind_next   = req.kind;
                    sign_next   = req.sign;
                    mcand_next  = req.mag;
                    acc_next    = '0;
                    cnt_next    = MUL_LAST;
                    mplier_next = (req.kind == CVT_S2D) ? ROT_ODD : spr;
                    dvsr_next   = (req.kind == CVT_S2D) ? spr : ROT_ODD;
                    state_next  = CV_MUL;
                end
            end
            CV_MUL:
            begin
                // msb first: acc = 2*acc + bit*mcand
                acc_next = {acc_reg[PROD_W-2:0], 1'b0}
                         + (mplier_reg[SPR_W-1] ? {{(PROD_W-ANGLE_W){1'b0}}, mcand_reg}
                                                : {PROD_W{1'b0}});
                mplier_next = {mplier_reg[SPR_W-2:0], 1'b0};
                if (cnt_reg == '0)
                begin
                    state_next = CV_PREP;
                end
                else
                begin
                    cnt_next = cnt_reg - 6'd1;
                end
            end
            CV_PREP:
            begin
                // d2s: round by half a turn, then the 2^11 part of 92160 is a shift
                // s2d: the 2^11 part of 92160 is a shift up
                if (kind_reg == CVT_D2S)
                begin
                    quo_next = {{(ROT_SHIFT-1){1'b0}}, round_sum[PROD_W:ROT_SHIFT]};
                end
                else
                begin
                    quo_next = {acc_reg[PROD_W-ROT_SHIFT-1:0], {ROT_SHIFT{1'b0}}};
                end
                rem_next   = '0;
                cnt_next   = DIV_LAST;
                state_next = CV_DIV;
            end
            CV_DIV:
            begin
                quo_next = {quo_reg[PROD_W-2:0], rem_fits};
                rem_next = rem_fits ? rem_diff[SPR_W-1:0] : rem_ext[SPR_W-1:0];
                if (cnt_reg == '0)
                begin
                    state_next = CV_FIN;
                end
                else
                begin
                    cnt_next = cnt_reg - 6'd1;
                end
            end
            CV_FIN:
            begin
                state_next = CV_IDLE;
            end
            default:
            begin
                state_next = CV_IDLE;
            end
        endcase
    end

    // sign of the magnitude quotient, saturated for step-to-degree results
    always_comb
    begin
        q_low = quo_reg[ANGLE_W-1:0];
        q_big = |quo_reg[PROD_W-1:ANGLE_W];
        if (kind_reg == CVT_D2S)
        begin
            result = sign_reg ? (~q_low + 32'd1) : q_low;
        end
        else if (!sign_reg)
        begin
            result = (q_big || q_low[ANGLE_W-1]) ? 32'h7FFF_FFFF : q_low;
        end
        else
        begin
            result = (q_big || (q_low[ANGLE_W-1] && (|q_low[ANGLE_W-2:0])))
                   ? 32'h8000_0000 : (~q_low + 32'd1);
        end
    end

    assign rsp.done   = (state_reg == CV_FIN);
    assign rsp.result = result;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CV_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg   <= kind_next;
        sign_reg   <= sign_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        acc_reg    <= acc_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        dvsr_reg   <= dvsr_next;
    end

endmodule

### hw/rtl/stepper_angle_position_controller.sv
// each angle/step conversion holds the bit-serial converter for its whole run
// (start, 16 multiply steps, prep, 48 divide steps, finish); one command at a time
// tick, forward, reverse, stop: one conversion, then the result is registered
// rotate_by and set_zero: two conversions; rotate_to: three
// result register loads once empty or taken; the next command is let in as it loads
// async active-low reset: stopped, position and goals zero, 200 steps/turn
`timescale 1ns / 1ps

module stepper_angle_position_controller (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [sapc_pkg::SPR_W-1:0] cfg_wdata,
    sapc_cmd_if.sink                   cmd,
    sapc_res_if.source                 res
);
    import sapc_pkg::*;

    typedef enum logic [6:0] {
        PH_IDLE  = 7'b0000001,
        PH_GOAL  = 7'b0000010,
        PH_REPLY = 7'b0000100,
        PH_ZERO  = 7'b0001000,
        PH_POS   = 7'b0010000,
        PH_AIM   = 7'b0100000,
        PH_OUT   = 7'b1000000
    } phase_t;

    phase_t              phase_reg, phase_next;
    logic                go_reg, go_next;
    logic [2:0]          act_reg, act_next;
    logic [ANGLE_W-1:0]  angle_reg, angle_next;
    logic [SPR_W-1:0]    spr_reg;
    logic [2:0]          mode_reg, mode_next;
    logic [ANGLE_W-1:0]  pos_reg, pos_next;
    logic [ANGLE_W-1:0]  goal_steps_reg, goal_steps_next;
    logic [ANGLE_W-1:0]  goal_angle_reg, goal_angle_next;
    logic [1:0]          pulse_reg, pulse_next;
    logic [ANGLE_W-1:0]  posdeg_reg, posdeg_next;
    logic [ANGLE_W-1:0]  reply_reg, reply_next;
    logic                out_valid_reg, out_valid_next;
    logic [1:0]          o_pulse_reg, o_pulse_next;
    logic [ANGLE_W-1:0]  o_posdeg_reg, o_posdeg_next;
    logic [ANGLE_W-1:0]  o_target_reg, o_target_next;
    logic [ANGLE_W-1:0]  o_reply_reg, o_reply_next;
    logic [2:0]          o_mode_reg, o_mode_next;

    logic [SPR_W-1:0]    spr_eff;
    logic                accept;
    logic [ANGLE_W-1:0]  opnd;
    logic                opnd_neg;
    cvt_kind_t           opnd_kind;
    cvt_req_t            cvt_req;
    cvt_rsp_t            cvt_rsp;
    logic [ANGLE_W:0]    aim_sum;
    logic [ANGLE_W-1:0]  aim_sat;

    assign spr_eff   = (spr_reg == '0) ? 16'd1 : spr_reg;
    assign cmd.ready = (phase_reg == PH_IDLE);
    assign accept    = cmd.valid && cmd.ready;

    // converter operand for the current phase
    always_comb
    begin
        opnd_neg  = 1'b0;
        opnd_kind = CVT_S2D;
        case (phase_reg)
            PH_GOAL:
            begin
                opnd      = angle_reg;
                opnd_kind = CVT_D2S;
            end
            PH_ZERO:
            begin
                opnd      = angle_reg;
                opnd_neg  = 1'b1;
                opnd_kind = CVT_D2S;
            end
            PH_REPLY: opnd = goal_steps_reg;
            PH_AIM:
            begin
                opnd      = goal_angle_reg;
                opnd_kind = CVT_D2S;
            end
            default:  opnd = pos_reg;
        endcase
        cvt_req.start = go_reg;
        cvt_req.kind  = opnd_kind;
        cvt_req.sign  = opnd[ANGLE_W-1] ^ opnd_neg;
        cvt_req.mag   = opnd[ANGLE_W-1] ? (~opnd + 32'd1) : opnd;
    end

    sapc_cvt u_cvt (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (cvt_req),
        .spr   (spr_eff),
        .rsp   (cvt_rsp)
    );

    // rotate_by target: position angle plus offset, saturated
    always_comb
    begin
        aim_sum = {cvt_rsp.result[ANGLE_W-1], cvt_rsp.result}
                + {angle_reg[ANGLE_W-1], angle_reg};
        if (aim_sum[ANGLE_W] != aim_sum[ANGLE_W-1])
        begin
            aim_sat = aim_sum[ANGLE_W] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
        else
        begin
            aim_sat = aim_sum[ANGLE_W-1:0];
        end
    end

    always_comb
    begin
        phase_next      = phase_reg;
        go_next         = 1'b0;
        act_next        = act_reg;
        angle_next      = angle_reg;
        mode_next       = mode_reg;
        pos_next        = pos_reg;
        goal_steps_next = goal_steps_reg;
        goal_angle_next = goal_angle_reg;
        pulse_next      = pulse_reg;
        posdeg_next     = posdeg_reg;
        reply_next      = reply_reg;
        out_valid_next  = out_valid_reg;
        o_pulse_next    = o_pulse_reg;
        o_posdeg_next   = o_posdeg_reg;
        o_target_next   = o_target_reg;
        o_reply_next    = o_reply_reg;
        o_mode_next     = o_mode_reg;

        if (out_valid_reg && res.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (phase_reg)
            PH_IDLE:
            begin
                if (accept)
                begin
                    act_next   = cmd.action;
                    angle_next = cmd.angle;
                    pulse_next = PULSE_NONE;
                    reply_next = '0;
                    go_next    = 1'b1;
                    phase_next = PH_POS;
                    case (cmd.action)
                        ACT_TICK:
                        begin
                            if (mode_reg == MODE_FORWARD)
                            begin
                                pulse_next = PULSE_FWD;
                                pos_next   = pos_reg + 32'd1;
                            end
                            else if (mode_reg == MODE_REVERSE)
                            begin
                                pulse_next = PULSE_BWD;
                                pos_next   = pos_reg - 32'd1;
                            end
                            else if (mode_reg == MODE_TARGET)
                            begin
                                if ($signed(pos_reg) < $signed(goal_steps_reg))
                                begin
                                    pulse_next = PULSE_FWD;
                                    pos_next   = pos_reg + 32'd1;
                                end
                                else if ($signed(pos_reg) > $signed(goal_steps_reg))
                                begin
                                    pulse_next = PULSE_BWD;
                                    pos_next   = pos_reg - 32'd1;
                                end
                                else
                                begin
                                    mode_next = MODE_REACHED;
                                end
                            end
                        end
                        ACT_FORWARD: mode_next = MODE_FORWARD;
                        ACT_REVERSE: mode_next = MODE_REVERSE;
                        ACT_STOP:    mode_next = MODE_STOPPED;
                        ACT_ROTATE_TO:
                        begin
                            goal_angle_next = cmd.angle;
                            mode_next       = MODE_TARGET;
                            phase_next      = PH_GOAL;
                        end
                        ACT_ROTATE_BY: mode_next = MODE_TARGET;
                        ACT_SET_ZERO:  phase_next = PH_ZERO;
                        default: ;
                    endcase
                end
            end
            PH_GOAL:
            begin
                if (cvt_rsp.done)
                begin
                    goal_steps_next = cvt_rsp.result;
                    go_next         = 1'b1;
                    phase_next      = PH_REPLY;
                end
            end
            PH_REPLY:
            begin
                if (cvt_rsp.done)
                begin
                    reply_next = cvt_rsp.result;
                    go_next    = 1'b1;
                    phase_next = PH_POS;
                end
            end
            PH_ZERO:
            begin
                if (cvt_rsp.done)
                begin
                    pos_next   = cvt_rsp.result;
                    go_next    = 1'b1;
                    phase_next = PH_POS;
                end
            end
            PH_POS:
            begin
                if (cvt_rsp.done)
                begin
                    posdeg_next = cvt_rsp.result;
                    if (act_reg == ACT_ROTATE_BY)
                    begin
                        goal_angle_next = aim_sat;
                        reply_next      = aim_sat;
                        go_next         = 1'b1;
                        phase_next      = PH_AIM;
                    end
                    else
                    begin
                        phase_next = PH_OUT;
                    end
                end
            end
            PH_AIM:
            begin
                if (cvt_rsp.done)
                begin
                    goal_steps_next = cvt_rsp.result;
                    phase_next      = PH_OUT;
                end
            end
            PH_OUT:
            begin
                if (!out_valid_reg || res.ready)
                begin
                    out_valid_next = 1'b1;
                    o_pulse_next   = pulse_reg;
                    o_posdeg_next  = posdeg_reg;
                    o_target_next  = goal_angle_reg;
                    o_reply_next   = reply_reg;
                    o_mode_next    = mode_reg;
                    phase_next     = PH_IDLE;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    assign res.valid            = out_valid_reg;
    assign res.step_pulse       = o_pulse_reg;
    assign res.position_degrees = o_posdeg_reg;
    assign res.target_degrees   = o_target_reg;
    assign res.reply_degrees    = o_reply_reg;
    assign res.mode             = o_mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            go_reg         <= 1'b0;
            spr_reg        <= SPR_RESET;
            mode_reg       <= MODE_STOPPED;
            pos_reg        <= '0;
            goal_steps_reg <= '0;
            goal_angle_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            go_reg         <= go_next;
            if (cfg_we)
            begin
                spr_reg <= cfg_wdata;
            end
            mode_reg       <= mode_next;
            pos_reg        <= pos_next;
            goal_steps_reg <= goal_steps_next;
            goal_angle_reg <= goal_angle_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg      <= act_next;
        angle_reg    <= angle_next;
        pulse_reg    <= pulse_next;
        posdeg_reg   <= posdeg_next;
        reply_reg    <= reply_next;
        o_pulse_reg  <= o_pulse_next;
        o_posdeg_reg <= o_posdeg_next;
        o_target_reg <= o_target_next;
        o_reply_reg  <= o_reply_next;
        o_mode_reg   <= o_mode_next;
    end

endmodule

### hw/rtl/sapc_checker.sv
// port-level checker for the stepper angle position controller, with its bind
// depends on sapc_pkg and stepper_angle_position_controller_macros.svh
`timescale 1ns / 1ps
`include "stepper_angle_position_controller_macros.svh"

module sapc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        cmd_valid,
    input logic        cmd_ready,
    input logic        res_valid,
    input logic        res_ready,
    input logic [1:0]  res_step_pulse,
    input logic [31:0] res_position_degrees,
    input logic [31:0] res_target_degrees,
    input logic [31:0] res_reply_degrees,
    input logic [2:0]  res_mode
);
    import sapc_pkg::*;

    // a stalled result stays put
    `SAPC_ASSERT_NEXT(a_res_hold, clk, rst_n, res_valid && !res_ready, res_valid && $stable(res_step_pulse) && $stable(res_position_degrees) && $stable(res_target_degrees) && $stable(res_reply_degrees) && $stable(res_mode), "result changed while stalled")

    // one command in flight at a time
    `SAPC_ASSERT_NEXT(a_one_cmd, clk, rst_n, cmd_valid && cmd_ready, !cmd_ready, "command taken while busy")

    `SAPC_ASSERT_SAME(a_fwd_mode, clk, rst_n, res_valid && (res_step_pulse == PULSE_FWD), (res_mode == MODE_FORWARD) || (res_mode == MODE_TARGET), "forward step outside forward or targeting")

    `SAPC_ASSERT_SAME(a_bwd_mode, clk, rst_n, res_valid && (res_step_pulse == PULSE_BWD), (res_mode == MODE_REVERSE) || (res_mode == MODE_TARGET), "backward step outside reverse or targeting")

    `SAPC_ASSERT_SAME(a_reached_still, clk, rst_n, res_valid && (res_mode == MODE_REACHED), res_step_pulse == PULSE_NONE, "step issued in reached mode")

endmodule

bind stepper_angle_position_controller sapc_checker u_sapc_checker (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd_valid            (cmd.valid),
    .cmd_ready            (cmd.ready),
    .res_valid            (res.valid),
    .res_ready            (res.ready),
    .res_step_pulse       (res.step_pulse),
    .res_position_degrees (res.position_degrees),
    .res_target_degrees   (res.target_degrees),
    .res_reply_degrees    (res.reply_degrees),
    .res_mode             (res.mode)
);
